// ===== design/jsu_pkg.sv =====
// shared types and constants for the json string unescaper
// no dependencies; used by every module of the block

package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
    localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_LO = 16'hDC00;
    localparam logic [15:0] LOW_SURR_HI = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

    // scanner modes
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_BODY = 2'd1,
        MODE_ESC = 2'd2,
        MODE_HEX = 2'd3
    } t_mode_e;

    // what the back end sends after an optional replacement character
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_RAW = 3'd1,
        OP_CP = 3'd2,
        OP_END = 3'd3,
        OP_ERR = 3'd4
    } t_op_e;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END = 2'd1,
        KIND_ERR = 2'd2
    } t_kind_e;

    // one queued command, produced per input beat that gives results
    typedef struct packed {
        logic pre_fffd;
        t_op_e op;
        logic [20:0] cp;
    } t_cmd;

endpackage

// ===== design/jsu_front.sv =====
// front end: scans input bytes, tracks escapes and surrogates, emits commands
// depends on jsu_pkg

module jsu_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    output logic           o_push,
    output jsu_pkg::t_cmd  o_cmd
);

    jsu_pkg::t_mode_e r_mode, n_mode;
    logic [15:0] r_accum, n_accum;
    logic [1:0] r_count, n_count;
    logic [15:0] r_pend_hi, n_pend_hi;
    logic r_pend, n_pend;

    logic [4:0] hex_v;
    logic [7:0] simple_d;
    logic simple_ok;
    logic [15:0] acc_next;
    logic is_high, is_low;
    jsu_pkg::t_cmd cmd;

    // bit 4 flags a bad digit
    always_comb begin
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_v = {1'b0, i_byte[3:0]};
        end else if ((i_byte >= 8'h61 && i_byte <= 8'h66) ||
                     (i_byte >= 8'h41 && i_byte <= 8'h46)) begin
            hex_v = {1'b0, i_byte[3:0] + 4'd9};
        end else begin
            hex_v = 5'h10;
        end
    end

    always_comb begin
        simple_ok = 1'b1;
        case (i_byte)
            jsu_pkg::CH_QUOTE:  simple_d = jsu_pkg::CH_QUOTE;
            jsu_pkg::CH_BSLASH: simple_d = jsu_pkg::CH_BSLASH;
            jsu_pkg::CH_SLASH:  simple_d = jsu_pkg::CH_SLASH;
            8'h62:              simple_d = 8'h08;
            8'h66:              simple_d = 8'h0C;
            8'h6E:              simple_d = 8'h0A;
            8'h72:              simple_d = 8'h0D;
            8'h74:              simple_d = 8'h09;
            default: begin
                simple_d = 8'h00;
                simple_ok = 1'b0;
            end
        endcase
    end

    assign acc_next = {r_accum[11:0], hex_v[3:0]};
    assign is_high = (acc_next >= jsu_pkg::HIGH_SURR_LO) && (acc_next <= jsu_pkg::HIGH_SURR_HI);
    assign is_low = (acc_next >= jsu_pkg::LOW_SURR_LO) && (acc_next <= jsu_pkg::LOW_SURR_HI);

    // next mode
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            jsu_pkg::MODE_IDLE: begin
                if (i_byte == jsu_pkg::CH_QUOTE) n_mode = jsu_pkg::MODE_BODY;
            end
            jsu_pkg::MODE_BODY: begin
                if (i_byte == jsu_pkg::CH_NUL || i_byte == jsu_pkg::CH_QUOTE) begin
                    n_mode = jsu_pkg::MODE_IDLE;
                end else if (i_byte == jsu_pkg::CH_BSLASH) begin
                    n_mode = jsu_pkg::MODE_ESC;
                end
            end
            jsu_pkg::MODE_ESC: begin
                if (i_byte == 8'h75) n_mode = jsu_pkg::MODE_HEX;
                else if (simple_ok) n_mode = jsu_pkg::MODE_BODY;
                else n_mode = jsu_pkg::MODE_IDLE;
            end
            jsu_pkg::MODE_HEX: begin
                if (hex_v[4]) n_mode = jsu_pkg::MODE_IDLE;
                else if (r_count == 2'd3) n_mode = jsu_pkg::MODE_BODY;
            end
            default: n_mode = jsu_pkg::MODE_IDLE;
        endcase
    end

    // commands and datapath
    always_comb begin
        n_accum = r_accum;
        n_count = r_count;
        n_pend = r_pend;
        n_pend_hi = r_pend_hi;
        cmd.pre_fffd = 1'b0;
        cmd.op = jsu_pkg::OP_NONE;
        cmd.cp = 21'd0;
        case (r_mode)
            jsu_pkg::MODE_IDLE: begin
                if (i_byte == jsu_pkg::CH_QUOTE) begin
                    n_accum = 16'd0;
                    n_count = 2'd0;
                    n_pend = 1'b0;
                    n_pend_hi = 16'd0;
                end
            end
            jsu_pkg::MODE_BODY: begin
                if (i_byte == jsu_pkg::CH_NUL) begin
                    cmd.op = jsu_pkg::OP_ERR;
                    n_pend = 1'b0;
                    n_pend_hi = 16'd0;
                end else if (i_byte == jsu_pkg::CH_QUOTE) begin
                    cmd.pre_fffd = r_pend;
                    cmd.op = jsu_pkg::OP_END;
                    n_pend = 1'b0;
                    n_pend_hi = 16'd0;
                end else if (i_byte != jsu_pkg::CH_BSLASH) begin
                    cmd.pre_fffd = r_pend;
                    cmd.op = jsu_pkg::OP_RAW;
                    cmd.cp = {13'd0, i_byte};
                    n_pend = 1'b0;
                    n_pend_hi = 16'd0;
                end
            end
            jsu_pkg::MODE_ESC: begin
                if (i_byte == 8'h75) begin
                    n_accum = 16'd0;
                    n_count = 2'd0;
                end else if (simple_ok) begin
                    cmd.pre_fffd = r_pend;
                    cmd.op = jsu_pkg::OP_RAW;
                    cmd.cp = {13'd0, simple_d};
                    n_pend = 1'b0;
                    n_pend_hi = 16'd0;
                end else begin
                    cmd.op = jsu_pkg::OP_ERR;
                    n_accum = 16'd0;
                    n_count = 2'd0;
                    n_pend = 1'b0;
                    n_pend_hi = 16'd0;
                end
            end
            jsu_pkg::MODE_HEX: begin
                if (hex_v[4]) begin
                    cmd.op = jsu_pkg::OP_ERR;
                    n_accum = 16'd0;
                    n_count = 2'd0;
                    n_pend = 1'b0;
                    n_pend_hi = 16'd0;
                end else if (r_count == 2'd3) begin
                    n_accum = 16'd0;
                    n_count = 2'd0;
                    if (r_pend && is_low) begin
                        // pair the held high half with this low half
                        cmd.op = jsu_pkg::OP_CP;
                        cmd.cp = jsu_pkg::SUPP_BASE +
                                 {1'b0, r_pend_hi[9:0], acc_next[9:0]};
                        n_pend = 1'b0;
                        n_pend_hi = 16'd0;
                    end else begin
                        cmd.pre_fffd = r_pend;
                        n_pend = 1'b0;
                        n_pend_hi = 16'd0;
                        if (is_high) begin
                            n_pend = 1'b1;
                            n_pend_hi = acc_next;
                        end else if (is_low) begin
                            cmd.op = jsu_pkg::OP_CP;
                            cmd.cp = jsu_pkg::REPLACEMENT_CP;
                        end else begin
                            cmd.op = jsu_pkg::OP_CP;
                            cmd.cp = {5'd0, acc_next};
                        end
                    end
                end else begin
                    n_accum = acc_next;
                    n_count = r_count + 2'd1;
                end
            end
            default: begin
                n_accum = r_accum;
            end
        endcase
    end

    assign o_cmd = cmd;
    assign o_push = i_accept && (cmd.pre_fffd || (cmd.op != jsu_pkg::OP_NONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jsu_pkg::MODE_IDLE;
            r_accum <= 16'd0;
            r_count <= 2'd0;
            r_pend <= 1'b0;
            r_pend_hi <= 16'd0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_accum <= n_accum;
            r_count <= n_count;
            r_pend <= n_pend;
            r_pend_hi <= n_pend_hi;
        end
    end

endmodule

// ===== design/jsu_queue.sv =====
// short command queue between front and back end
// depends on jsu_pkg

module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jsu_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output jsu_pkg::t_cmd  o_cmd,
    output logic           o_valid,
    output logic           o_full
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkg::t_cmd r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic do_push, do_pop;

    function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] q;
        if (p == IDX_W'(DEPTH - 1)) q = '0;
        else q = p + IDX_W'(1);
        return q;
    endfunction

    assign o_full = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= bump(r_wr);
            if (do_pop) r_rd <= bump(r_rd);
            if (do_push && !do_pop) r_count <= r_count + CNT_W'(1);
            else if (do_pop && !do_push) r_count <= r_count - CNT_W'(1);
        end
    end

endmodule

// ===== design/jsu_back.sv =====
// back end: expands commands into result beats, utf-8 encoding, output register
// depends on jsu_pkg

module jsu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  jsu_pkg::t_cmd  i_q_cmd,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_byte,
    output logic [1:0]     o_kind,
    output logic           o_last
);

    jsu_pkg::t_cmd r_cur;
    logic r_cur_valid;
    logic [2:0] r_idx;
    logic r_out_valid;
    logic [7:0] r_out_byte;
    logic [1:0] r_out_kind;
    logic r_out_last;

    logic [2:0] main_len, total, j;
    logic [7:0] sel_byte;
    jsu_pkg::t_kind_e sel_kind;
    logic slot_free, emit, at_end, load;

    always_comb begin
        if (r_cur.cp < 21'h80) main_len = 3'd1;
        else if (r_cur.cp < 21'h800) main_len = 3'd2;
        else if (r_cur.cp < 21'h10000) main_len = 3'd3;
        else main_len = 3'd4;
        case (r_cur.op)
            jsu_pkg::OP_NONE: main_len = 3'd0;
            jsu_pkg::OP_CP:   main_len = main_len;
            default:          main_len = 3'd1;
        endcase
    end

    assign total = (r_cur.pre_fffd ? 3'd3 : 3'd0) + main_len;
    assign j = r_cur.pre_fffd ? r_idx - 3'd3 : r_idx;

    always_comb begin
        sel_byte = 8'h00;
        sel_kind = jsu_pkg::KIND_DATA;
        if (r_cur.pre_fffd && r_idx < 3'd3) begin
            // replacement character ef bf bd
            case (r_idx)
                3'd0:    sel_byte = 8'hEF;
                3'd1:    sel_byte = 8'hBF;
                default: sel_byte = 8'hBD;
            endcase
        end else begin
            case (r_cur.op)
                jsu_pkg::OP_RAW: sel_byte = r_cur.cp[7:0];
                jsu_pkg::OP_END: sel_kind = jsu_pkg::KIND_END;
                jsu_pkg::OP_ERR: sel_kind = jsu_pkg::KIND_ERR;
                jsu_pkg::OP_CP: begin
                    case (main_len)
                        3'd1: sel_byte = r_cur.cp[7:0];
                        3'd2: begin
                            if (j == 3'd0) sel_byte = {3'b110, r_cur.cp[10:6]};
                            else sel_byte = {2'b10, r_cur.cp[5:0]};
                        end
                        3'd3: begin
                            case (j)
                                3'd0:    sel_byte = {4'b1110, r_cur.cp[15:12]};
                                3'd1:    sel_byte = {2'b10, r_cur.cp[11:6]};
                                default: sel_byte = {2'b10, r_cur.cp[5:0]};
                            endcase
                        end
                        default: begin
                            case (j)
                                3'd0:    sel_byte = {5'b11110, r_cur.cp[20:18]};
                                3'd1:    sel_byte = {2'b10, r_cur.cp[17:12]};
                                3'd2:    sel_byte = {2'b10, r_cur.cp[11:6]};
                                default: sel_byte = {2'b10, r_cur.cp[5:0]};
                            endcase
                        end
                    endcase
                end
                default: sel_byte = 8'h00;
            endcase
        end
    end

    assign slot_free = !r_out_valid || i_ready;
    assign emit = r_cur_valid && slot_free;
    assign at_end = (r_idx == total - 3'd1);
    assign load = i_q_valid && (!r_cur_valid || (emit && at_end));
    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_cur_valid <= 1'b1;
                r_idx <= 3'd0;
            end else if (emit && at_end) begin
                r_cur_valid <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 3'd1;
            end
            if (emit) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_cur <= i_q_cmd;
        if (emit) begin
            r_out_byte <= sel_byte;
            r_out_kind <= sel_kind;
            r_out_last <= at_end;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte = r_out_byte;
    assign o_kind = r_out_kind;
    assign o_last = r_out_last;

endmodule

// ===== design/json_string_unescaper.sv =====
// top level of the json string unescaper
// depends on jsu_pkg, jsu_front, jsu_queue, jsu_back

// Feed the bytes of a JSON string literal, opening quote first, one per beat on
// the slave stream. Raw bytes pass through, simple escapes decode to one byte,
// \uXXXX escapes come out as UTF-8 with surrogate pairs joined and lone halves
// replaced by U+FFFD. The closing quote gives an end beat (tuser 1) and any
// NUL, bad escape letter or bad hex digit gives an error beat (tuser 2); after
// either the block ignores bytes until the next opening quote. tlast marks the
// final result beat caused by one input byte. One input byte is taken per
// cycle while the command queue has room; the master side sends one result
// beat per cycle while m_axis_tready is high, a byte yields up to six results,
// and the queue of QUEUE_DEPTH commands between the scanner and the encoder
// absorbs the bursts.

module json_string_unescaper #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    // result stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast    // last
);

    logic accept;
    logic push, pop, q_valid, q_full;
    jsu_pkg::t_cmd front_cmd, head_cmd;

    // a beat is taken whenever the queue can hold its command
    assign s_axis_tready = !q_full;
    assign accept = s_axis_tvalid && s_axis_tready;

    // scanner: mode, hex gathering and held surrogate
    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    // decouples scanner from encoder
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    // encoder: one result beat per cycle into the output register while it is free
    jsu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_q_pop   (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_kind    (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

endmodule

// ===== bench/json_string_unescaper_tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for json_string_unescaper: a directed table, then random strings
// depends on jsu_pkg and the design sources; no files or arguments are read

module json_string_unescaper_tb;
    import jsu_pkg::*;

    localparam int ITEM_TARGET = 310;
    localparam int DRAIN_AT = 150;
    localparam int STALL_LIMIT = 2000;  // cycles with no beat moving on either side
    localparam int TAIL_CYCLES = 16;
    localparam int MAX_REPORTS = 10;
    localparam logic [1:0] HEX_LAST = 2'd3;

    // how a table row is checked
    typedef enum logic [1:0] {
        CHK_PREDICT = 2'd0,
        CHK_SILENT = 2'd1,
        CHK_SINGLE = 2'd2
    } t_check_e;

    typedef struct packed {
        logic [7:0] data;
        t_kind_e kind;
        logic last;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] b;
        t_check_e chk;
        logic [7:0] data;
        t_kind_e kind;
    } t_row;

    localparam logic [7:0] SIMPLE_ESC [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH,
                                              "b", "f", "n", "r", "t"};

    // directed table: typed results only where they are obvious
    localparam int N_ROWS = 28;
    localparam t_row DIRECTED [N_ROWS] = '{
        '{8'hFF, CHK_SILENT, 8'h00, KIND_DATA},      // stray byte before the quote
        '{CH_QUOTE, CHK_SILENT, 8'h00, KIND_DATA},
        '{CH_NUL, CHK_SINGLE, 8'h00, KIND_ERR},      // nul inside the body
        '{CH_QUOTE, CHK_SILENT, 8'h00, KIND_DATA},
        '{8'h01, CHK_SINGLE, 8'h01, KIND_DATA},      // lowest raw byte
        '{8'hFF, CHK_SINGLE, 8'hFF, KIND_DATA},      // highest raw byte
        '{CH_BSLASH, CHK_SILENT, 8'h00, KIND_DATA},
        '{"q", CHK_SINGLE, 8'h00, KIND_ERR},         // unknown escape letter
        '{CH_QUOTE, CHK_SILENT, 8'h00, KIND_DATA},
        '{CH_BSLASH, CHK_SILENT, 8'h00, KIND_DATA},  // \u0000 gives a zero data byte
        '{"u", CHK_SILENT, 8'h00, KIND_DATA},
        '{"0", CHK_SILENT, 8'h00, KIND_DATA},
        '{"0", CHK_SILENT, 8'h00, KIND_DATA},
        '{"0", CHK_SILENT, 8'h00, KIND_DATA},
        '{"0", CHK_SINGLE, 8'h00, KIND_DATA},
        '{CH_BSLASH, CHK_SILENT, 8'h00, KIND_DATA},
        '{"n", CHK_SINGLE, 8'h0A, KIND_DATA},
        '{CH_BSLASH, CHK_SILENT, 8'h00, KIND_DATA},  // \uDBFF is held back
        '{"u", CHK_SILENT, 8'h00, KIND_DATA},
        '{"D", CHK_SILENT, 8'h00, KIND_DATA},
        '{"b", CHK_SILENT, 8'h00, KIND_DATA},
        '{"F", CHK_SILENT, 8'h00, KIND_DATA},
        '{"f", CHK_SILENT, 8'h00, KIND_DATA},
        '{CH_QUOTE, CHK_PREDICT, 8'h00, KIND_DATA},  // held half replaced, then end
        '{CH_QUOTE, CHK_SILENT, 8'h00, KIND_DATA},
        '{CH_BSLASH, CHK_SILENT, 8'h00, KIND_DATA},
        '{"u", CHK_SILENT, 8'h00, KIND_DATA},
        '{"g", CHK_SINGLE, 8'h00, KIND_ERR}          // bad hex digit
    };

    // clock, reset and both streams; those the bench drives are known from time zero
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;    // [7:0] in_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic [1:0] m_axis_tuser;            // [1:0] kind
    logic       m_axis_tlast;

    // decoder state mirrored on the bench side
    t_mode_e     dec_mode = MODE_IDLE;
    logic [15:0] hex_accum = '0;
    logic [1:0]  hex_digits = '0;
    logic [15:0] held_high = '0;
    logic        held_valid = 1'b0;

    t_out_beat fresh_beats[$];   // results of the byte just taken
    t_out_beat due_beats[$];     // results still owed by the block

    t_check_e  row_check = CHK_PREDICT;
    t_out_beat row_beat = '0;
    logic      idle_off = 1'b0;
    int        items_taken = 0;
    int        mismatch_count = 0;
    int        idle_cycles = 0;

    json_string_unescaper u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void emit(input logic [7:0] d, input t_kind_e k);
        t_out_beat bt;
        bt.data = d;
        bt.kind = k;
        bt.last = 1'b0;
        fresh_beats.push_back(bt);
    endfunction

    // one code point as 1 to 4 utf-8 bytes
    function automatic void put_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            emit(cp[7:0], KIND_DATA);
        end else if (cp < 21'h800) begin
            emit(8'hC0 | {3'b0, cp[10:6]}, KIND_DATA);
            emit(8'h80 | {2'b0, cp[5:0]}, KIND_DATA);
        end else if (cp < SUPP_BASE) begin
            emit(8'hE0 | {4'b0, cp[15:12]}, KIND_DATA);
            emit(8'h80 | {2'b0, cp[11:6]}, KIND_DATA);
            emit(8'h80 | {2'b0, cp[5:0]}, KIND_DATA);
        end else begin
            emit(8'hF0 | {5'b0, cp[20:18]}, KIND_DATA);
            emit(8'h80 | {2'b0, cp[17:12]}, KIND_DATA);
            emit(8'h80 | {2'b0, cp[11:6]}, KIND_DATA);
            emit(8'h80 | {2'b0, cp[5:0]}, KIND_DATA);
        end
    endfunction

    // a held high half that finds no partner becomes the replacement character
    function automatic void drop_held();
        if (held_valid) begin
            put_code_point(REPLACEMENT_CP);
            held_valid = 1'b0;
            held_high = '0;
        end
    endfunction

    function automatic void abort_string();
        dec_mode = MODE_IDLE;
        hex_accum = '0;
        hex_digits = '0;
        held_valid = 1'b0;
        held_high = '0;
        emit(8'h00, KIND_ERR);
    endfunction

    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    // a complete \uXXXX: pair it, hold it or send it
    function automatic void close_unicode(input logic [15:0] cp);
        logic [20:0] full;
        logic        paired;
        paired = 1'b0;
        if (held_valid) begin
            if (cp >= LOW_SURR_LO && cp <= LOW_SURR_HI) begin
                full = SUPP_BASE + (21'(held_high - HIGH_SURR_LO) << 10)
                     + 21'(cp - LOW_SURR_LO);
                held_valid = 1'b0;
                held_high = '0;
                put_code_point(full);
                paired = 1'b1;
            end else begin
                drop_held();
            end
        end
        if (!paired) begin
            if (cp >= HIGH_SURR_LO && cp <= HIGH_SURR_HI) begin
                held_valid = 1'b1;
                held_high = cp;
            end else if (cp >= LOW_SURR_LO && cp <= LOW_SURR_HI) begin
                put_code_point(REPLACEMENT_CP);
            end else begin
                put_code_point({5'b0, cp});
            end
        end
    endfunction

    // works out every result one accepted byte causes, into fresh_beats
    function automatic void unescape_byte(input logic [7:0] b);
        int          v;
        logic        known;
        logic [7:0]  lit;
        logic [15:0] cp;
        t_out_beat   tail;
        fresh_beats.delete();
        case (dec_mode)
            MODE_BODY: begin
                if (b == CH_NUL) begin
                    abort_string();
                end else if (b == CH_QUOTE) begin
                    drop_held();
                    emit(8'h00, KIND_END);
                    dec_mode = MODE_IDLE;
                end else if (b == CH_BSLASH) begin
                    dec_mode = MODE_ESC;
                end else begin
                    drop_held();
                    emit(b, KIND_DATA);
                end
            end
            MODE_ESC: begin
                if (b == "u") begin
                    dec_mode = MODE_HEX;
                    hex_accum = '0;
                    hex_digits = '0;
                end else begin
                    known = 1'b1;
                    lit = 8'h00;
                    case (b)
                        CH_QUOTE:  lit = CH_QUOTE;
                        CH_BSLASH: lit = CH_BSLASH;
                        CH_SLASH:  lit = CH_SLASH;
                        "b":       lit = 8'h08;
                        "f":       lit = 8'h0C;
                        "n":       lit = 8'h0A;
                        "r":       lit = 8'h0D;
                        "t":       lit = 8'h09;
                        default:   known = 1'b0;
                    endcase
                    if (!known) begin
                        abort_string();
                    end else begin
                        drop_held();
                        emit(lit, KIND_DATA);
                        dec_mode = MODE_BODY;
                    end
                end
            end
            MODE_HEX: begin
                v = hex_digit_value(b);
                if (v < 0) begin
                    abort_string();
                end else begin
                    hex_accum = {hex_accum[11:0], 4'(v)};
                    if (hex_digits == HEX_LAST) begin
                        cp = hex_accum;
                        hex_accum = '0;
                        hex_digits = '0;
                        dec_mode = MODE_BODY;
                        close_unicode(cp);
                    end else begin
                        hex_digits = hex_digits + 2'd1;
                    end
                end
            end
            default: begin
                // everything but an opening quote is dropped here
                if (b == CH_QUOTE) begin
                    dec_mode = MODE_BODY;
                    hex_accum = '0;
                    hex_digits = '0;
                    held_valid = 1'b0;
                    held_high = '0;
                end
            end
        endcase
        if (fresh_beats.size() > 0) begin
            tail = fresh_beats[fresh_beats.size() - 1];
            tail.last = 1'b1;
            fresh_beats[fresh_beats.size() - 1] = tail;
        end
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endfunction

    // both handshakes sampled at the rising edge, input side first so a
    // same-cycle result always finds its expectation
    always @(posedge i_clk) begin : monitor
        logic      moved;
        t_out_beat got;
        t_out_beat want;
        moved = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                if (dec_mode != MODE_IDLE || s_axis_tdata == CH_QUOTE) items_taken++;
                unescape_byte(s_axis_tdata);
                // a typed row replaces the computed results
                if (row_check != CHK_PREDICT) begin
                    fresh_beats.delete();
                    if (row_check == CHK_SINGLE) fresh_beats.push_back(row_beat);
                end
                foreach (fresh_beats[i]) due_beats.push_back(fresh_beats[i]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                got.data = m_axis_tdata;
                got.kind = t_kind_e'(m_axis_tuser);
                got.last = m_axis_tlast;
                if (due_beats.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat data %02h kind %0d last %0b",
                                            got.data, got.kind, got.last));
                end else begin
                    want = due_beats.pop_front();
                    if (got.data != want.data || got.kind != want.kind
                            || got.last != want.last)
                        note_mismatch($sformatf(
                            "expected data %02h kind %0d last %0b, got %02h %0d %0b",
                            want.data, want.kind, want.last,
                            got.data, got.kind, got.last));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // nothing moved for too long: the block is hung
    initial begin : watchdog
        do @(posedge i_clk); while (idle_cycles < STALL_LIMIT);
        $display("json_string_unescaper regression: fail");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    // mostly back to back, now and then a short gap, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side: random stalls unless a quiet stretch is on
    initial begin : sink
        int stall;
        stall = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!idle_off) stall = pick_gap();
            end
        end
    end

    // one input beat; valid stays up into the next byte when no gap follows
    task automatic send_byte(input logic [7:0] b, input t_check_e chk = CHK_PREDICT,
                             input t_out_beat typed = '0);
        int gap;
        gap = idle_off ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        row_check = chk;
        row_beat = typed;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop sending until every owed result has come out
    task automatic wait_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (due_beats.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return "0" + 8'(n);
        return ($urandom_range(0, 1) ? "a" : "A") + 8'(n) - 8'd10;
    endfunction

    function automatic logic is_escape_letter(input logic [7:0] c);
        foreach (SIMPLE_ESC[i]) if (c == SIMPLE_ESC[i]) return 1'b1;
        return c == "u";
    endfunction

    task automatic send_unicode(input logic [15:0] cp);
        send_byte(CH_BSLASH);
        send_byte("u");
        for (int i = 3; i >= 0; i--) send_byte(hex_char(cp[i*4 +: 4]));
    endtask

    // \u escape from every utf-8 length, surrogate pairs and lone halves
    task automatic send_random_unicode();
        logic [15:0] cp;
        case ($urandom_range(0, 7))
            0: cp = $urandom_range(0, 3) == 0 ? 16'h0000 : 16'($urandom_range(0, 16'h7F));
            1: cp = 16'($urandom_range(16'h80, 16'h7FF));
            2: cp = 16'($urandom_range(16'h800, 16'hD7FF));
            3: cp = 16'($urandom_range(16'hE000, 16'hFFFF));
            4, 5: begin
                send_unicode(16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI)));
                cp = 16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI));
            end
            6: cp = 16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI));  // lone high half
            default: cp = 16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI));
        endcase
        send_unicode(cp);
    endtask

    // nul, bad escape letter or bad hex digit; the string ends there
    task automatic send_broken();
        logic [7:0] b;
        case ($urandom_range(0, 2))
            0: send_byte(CH_NUL);
            1: begin
                send_byte(CH_BSLASH);
                do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
                send_byte(b);
            end
            default: begin
                send_byte(CH_BSLASH);
                send_byte("u");
                repeat ($urandom_range(0, 3)) send_byte(hex_char(4'($urandom_range(0, 15))));
                do b = 8'($urandom_range(0, 255)); while (hex_digit_value(b) >= 0);
                send_byte(b);
            end
        endcase
    endtask

    // one literal: maybe some junk first, then a well-formed body or a broken one
    task automatic send_random_string();
        logic [7:0] b;
        int         tokens;
        int         r;
        idle_off = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
                send_byte(b);
            end
        end
        send_byte(CH_QUOTE);
        tokens = $urandom_range(0, 8);
        for (int i = 0; i < tokens; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
                send_byte(b);
            end else if (r < 45) begin
                send_byte(CH_BSLASH);
                send_byte(SIMPLE_ESC[3'($urandom_range(0, 7))]);
            end else if (r < 93) begin
                send_random_unicode();
            end else begin
                send_broken();
                return;
            end
        end
        send_byte(CH_QUOTE);
    endtask

    initial begin : main
        t_out_beat typed;
        logic      drained_mid;
        drained_mid = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (DIRECTED[i]) begin
            typed.data = DIRECTED[i].data;
            typed.kind = DIRECTED[i].kind;
            typed.last = 1'b1;
            send_byte(DIRECTED[i].b, DIRECTED[i].chk, typed);
        end
        wait_drain();

        // random strings, with one full pause about halfway
        while (items_taken < ITEM_TARGET) begin
            send_random_string();
            if (!drained_mid && items_taken >= DRAIN_AT) begin
                wait_drain();
                drained_mid = 1'b1;
            end
        end
        idle_off = 1'b0;
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && due_beats.size() == 0) begin
            $display("json_string_unescaper regression: pass");
        end else begin
            $display("json_string_unescaper regression: fail");
        end
        $finish;
    end

endmodule

// ===== json_string_unescaper.f =====
design/jsu_pkg.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescaper.sv
bench/json_string_unescaper_tb.sv
